>>> sv/pcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  // Field widths.
  localparam int BIN_W   = 6;
  localparam int CNT_W   = 48;
  localparam int OBJ_W   = 25;
  localparam int NORM_W  = 48;
  localparam int SHELL_W = 14;
  localparam int CORR_W  = 32;
  localparam int ERR_W   = 31;

  // Square root of the count in Q.8: the radicand is the count shifted up by 16.
  localparam int RAD_W     = CNT_W + 16;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQREM_W   = ROOT_W + 3;
  localparam int SQ_STAGES = ROOT_W;

  // Products and divider steps.
  localparam int PROD_W    = CNT_W + NORM_W;
  localparam int EPROD_W   = NORM_W + ROOT_W;
  localparam int HALF_W    = NORM_W / 2;
  localparam int DIV_STEPS = CORR_W;

  // The correlation quotient saturates at 2^31-1 plus one in Q15.16.
  localparam logic [CORR_W:0]   CORR_LIMIT  = 33'h0_8000_FFFF;
  localparam logic [CORR_W-1:0] CORR_OFFSET = 32'h0001_0000;
  localparam logic [ERR_W-1:0]  ERR_SAT     = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJECT_COUNT = 1'b0,
    REG_SHELL_NORM   = 1'b1
  } cfg_reg_t;

  // One classified bin as it travels from the front end to the back end.
  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [CNT_W-1:0]   cnt;
    logic [SHELL_W-1:0] shell;
    logic               clamped;
    logic               zero;
  } bin_item_t;

  // Shell factor 3i^2+3i+1 of a linear radial bin.
  function automatic logic [SHELL_W-1:0] shell_factor(input logic [BIN_W-1:0] b);
    logic [SHELL_W-1:0] bb;
    bb = {{(SHELL_W-BIN_W){1'b0}}, b};
    return SHELL_W'(3 * bb * bb + 3 * bb + 1);
  endfunction

endpackage

`default_nettype wire

>>> sv/pcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcc_front import pcc_pkg::*; (
  input  logic [BIN_W-1:0] bin_index,
  input  logic [CNT_W-1:0] pair_count,
  input  logic [OBJ_W-1:0] object_count,
  output bin_item_t        item
);

  logic [CNT_W-1:0] oc_ext;
  logic             below;

  // Remove self pairs from bin zero, clamp at zero, and look up the shell factor.
  always_comb begin
    oc_ext       = {{(CNT_W-OBJ_W){1'b0}}, object_count};
    below        = (bin_index == '0) && (pair_count < oc_ext);
    item.bin     = bin_index;
    item.shell   = shell_factor(bin_index);
    item.clamped = below;
    if (bin_index != '0) begin
      item.cnt = pair_count;
    end else if (below) begin
      item.cnt = '0;
    end else begin
      item.cnt = pair_count - oc_ext;
    end
    item.zero = (item.cnt == '0);
  end

endmodule

`default_nettype wire

>>> sv/pcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pcc_queue import pcc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bin_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output bin_item_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bin_item_t        mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> sv/pcc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pcc_back import pcc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bin_item_t           head,
  input  logic                q_empty,
  output logic                pop,
  input  logic [NORM_W-1:0]   shell_norm,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BIN_W-1:0]    out_bin,
  output logic [CORR_W-1:0]   out_corr,
  output logic [ERR_W-1:0]    out_err,
  output logic                out_clamped
);

  logic adv;

  // Square root stages.
  logic               sq_v_r    [SQ_STAGES];
  bin_item_t          sq_item_r [SQ_STAGES];
  logic [RAD_W-1:0]   sq_x_r    [SQ_STAGES];
  logic [SQREM_W-1:0] sq_rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0]  sq_root_r [SQ_STAGES];
  logic               sq_v_nxt    [SQ_STAGES];
  bin_item_t          sq_item_nxt [SQ_STAGES];
  logic [RAD_W-1:0]   sq_x_nxt    [SQ_STAGES];
  logic [SQREM_W-1:0] sq_rem_nxt  [SQ_STAGES];
  logic [ROOT_W-1:0]  sq_root_nxt [SQ_STAGES];

  // Partial products and their sums.
  logic                  m1_v_r;
  bin_item_t             m1_item_r;
  logic [2*HALF_W-1:0]   m1_p00_r, m1_p01_r, m1_p10_r, m1_p11_r;
  logic [HALF_W+ROOT_W-1:0] m1_e0_r, m1_e1_r;
  logic                  m2_v_r;
  bin_item_t             m2_item_r;
  logic [PROD_W-1:0]     m2_prod_r;
  logic [EPROD_W-1:0]    m2_eprod_r;

  // Divider stages; entry zero is the setup stage.
  logic               dv_v_r     [DIV_STEPS+1];
  bin_item_t          dv_item_r  [DIV_STEPS+1];
  logic               dv_covf_r  [DIV_STEPS+1];
  logic [SHELL_W-1:0] dv_crem_r  [DIV_STEPS+1];
  logic [CORR_W-1:0]  dv_clo_r   [DIV_STEPS+1];
  logic [CORR_W-1:0]  dv_cq_r    [DIV_STEPS+1];
  logic               dv_eovf_r  [DIV_STEPS+1];
  logic [SHELL_W-1:0] dv_erem_r  [DIV_STEPS+1];
  logic [ERR_W-1:0]   dv_elo_r   [DIV_STEPS+1];
  logic [ERR_W-1:0]   dv_eq_r    [DIV_STEPS+1];
  logic               dv_v_nxt    [DIV_STEPS+1];
  bin_item_t          dv_item_nxt [DIV_STEPS+1];
  logic               dv_covf_nxt [DIV_STEPS+1];
  logic [SHELL_W-1:0] dv_crem_nxt [DIV_STEPS+1];
  logic [CORR_W-1:0]  dv_clo_nxt  [DIV_STEPS+1];
  logic [CORR_W-1:0]  dv_cq_nxt   [DIV_STEPS+1];
  logic               dv_eovf_nxt [DIV_STEPS+1];
  logic [SHELL_W-1:0] dv_erem_nxt [DIV_STEPS+1];
  logic [ERR_W-1:0]   dv_elo_nxt  [DIV_STEPS+1];
  logic [ERR_W-1:0]   dv_eq_nxt   [DIV_STEPS+1];

  // Output register.
  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r,  out_bin_nxt;
  logic [CORR_W-1:0] out_corr_r, out_corr_nxt;
  logic [ERR_W-1:0]  out_err_r,  out_err_nxt;
  logic              out_clamped_r;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv         = !out_valid_r || out_ready;
  assign pop         = adv && !q_empty;
  assign out_valid   = out_valid_r;
  assign out_bin     = out_bin_r;
  assign out_corr    = out_corr_r;
  assign out_err     = out_err_r;
  assign out_clamped = out_clamped_r;

  // Digit-by-digit square root, one result bit per stage.
  always_comb begin
    logic               v_in;
    bin_item_t          item_in;
    logic [RAD_W-1:0]   x_in;
    logic [SQREM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]  root_in;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        v_in    = !q_empty;
        item_in = head;
        x_in    = {head.cnt, 16'h0000};
        rem_in  = '0;
        root_in = '0;
      end else begin
        v_in    = sq_v_r[k-1];
        item_in = sq_item_r[k-1];
        x_in    = sq_x_r[k-1];
        rem_in  = sq_rem_r[k-1];
        root_in = sq_root_r[k-1];
      end
      rem_sh = {rem_in[SQREM_W-3:0], x_in[RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      sq_v_nxt[k]    = v_in;
      sq_item_nxt[k] = item_in;
      sq_x_nxt[k]    = {x_in[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem_nxt[k]  = rem_sh - trial;
        sq_root_nxt[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rem_sh;
        sq_root_nxt[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Divider setup splits off the high part, which flags saturation when not below
  // the shell. The later stages are restoring steps, one quotient bit per stage.
  always_comb begin
    logic [CNT_W-1:0]    c_hi;
    logic [EPROD_W-56:0] e_hi;
    logic [SHELL_W:0]    c_rs, e_rs, sh;
    c_hi = m2_prod_r[PROD_W-1 -: CNT_W];
    e_hi = m2_eprod_r[EPROD_W-1 -: (EPROD_W-55)];
    dv_v_nxt[0]    = m2_v_r;
    dv_item_nxt[0] = m2_item_r;
    dv_covf_nxt[0] = c_hi >= {{(CNT_W-SHELL_W){1'b0}}, m2_item_r.shell};
    dv_crem_nxt[0] = c_hi[SHELL_W-1:0];
    dv_clo_nxt[0]  = m2_prod_r[16 +: CORR_W];
    dv_cq_nxt[0]   = '0;
    dv_eovf_nxt[0] = e_hi >= {{(EPROD_W-55-SHELL_W){1'b0}}, m2_item_r.shell};
    dv_erem_nxt[0] = e_hi[SHELL_W-1:0];
    dv_elo_nxt[0]  = m2_eprod_r[24 +: ERR_W];
    dv_eq_nxt[0]   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh   = {1'b0, dv_item_r[k].shell};
      c_rs = {dv_crem_r[k], dv_clo_r[k][CORR_W-1]};
      e_rs = {dv_erem_r[k], dv_elo_r[k][ERR_W-1]};
      dv_v_nxt[k+1]    = dv_v_r[k];
      dv_item_nxt[k+1] = dv_item_r[k];
      dv_covf_nxt[k+1] = dv_covf_r[k];
      dv_eovf_nxt[k+1] = dv_eovf_r[k];
      dv_clo_nxt[k+1]  = {dv_clo_r[k][CORR_W-2:0], 1'b0};
      if (c_rs >= sh) begin
        dv_crem_nxt[k+1] = SHELL_W'(c_rs - sh);
        dv_cq_nxt[k+1]   = {dv_cq_r[k][CORR_W-2:0], 1'b1};
      end else begin
        dv_crem_nxt[k+1] = c_rs[SHELL_W-1:0];
        dv_cq_nxt[k+1]   = {dv_cq_r[k][CORR_W-2:0], 1'b0};
      end
      // The error quotient is one bit shorter; its last stage passes through.
      if (k < ERR_W) begin
        dv_elo_nxt[k+1] = {dv_elo_r[k][ERR_W-2:0], 1'b0};
        if (e_rs >= sh) begin
          dv_erem_nxt[k+1] = SHELL_W'(e_rs - sh);
          dv_eq_nxt[k+1]   = {dv_eq_r[k][ERR_W-2:0], 1'b1};
        end else begin
          dv_erem_nxt[k+1] = e_rs[SHELL_W-1:0];
          dv_eq_nxt[k+1]   = {dv_eq_r[k][ERR_W-2:0], 1'b0};
        end
      end else begin
        dv_elo_nxt[k+1]  = dv_elo_r[k];
        dv_erem_nxt[k+1] = dv_erem_r[k];
        dv_eq_nxt[k+1]   = dv_eq_r[k];
      end
    end
  end

  // Saturation and the zero-count case.
  always_comb begin
    logic [CORR_W:0] c_sat;
    if (dv_covf_r[DIV_STEPS] || ({1'b0, dv_cq_r[DIV_STEPS]} > CORR_LIMIT)) begin
      c_sat = CORR_LIMIT;
    end else begin
      c_sat = {1'b0, dv_cq_r[DIV_STEPS]};
    end
    out_bin_nxt = dv_item_r[DIV_STEPS].bin;
    if (dv_item_r[DIV_STEPS].zero) begin
      out_corr_nxt = '0;
      out_err_nxt  = '0;
    end else begin
      out_corr_nxt = c_sat[CORR_W-1:0] - CORR_OFFSET;
      out_err_nxt  = dv_eovf_r[DIV_STEPS] ? ERR_SAT : dv_eq_r[DIV_STEPS];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_v_r[k] <= 1'b0;
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= 1'b0;
      end
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_v_r[k] <= sq_v_nxt[k];
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= dv_v_nxt[k];
      end
      m1_v_r      <= sq_v_r[SQ_STAGES-1];
      m2_v_r      <= m1_v_r;
      out_valid_r <= dv_v_r[DIV_STEPS];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_item_r[k] <= sq_item_nxt[k];
        sq_x_r[k]    <= sq_x_nxt[k];
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
      end
      // Partial products on half-width slices of the norm.
      m1_item_r <= sq_item_r[SQ_STAGES-1];
      m1_p00_r  <= sq_item_r[SQ_STAGES-1].cnt[HALF_W-1:0] * shell_norm[HALF_W-1:0];
      m1_p01_r  <= sq_item_r[SQ_STAGES-1].cnt[HALF_W-1:0] * shell_norm[NORM_W-1:HALF_W];
      m1_p10_r  <= sq_item_r[SQ_STAGES-1].cnt[CNT_W-1:HALF_W] * shell_norm[HALF_W-1:0];
      m1_p11_r  <= sq_item_r[SQ_STAGES-1].cnt[CNT_W-1:HALF_W] * shell_norm[NORM_W-1:HALF_W];
      m1_e0_r   <= shell_norm[HALF_W-1:0] * sq_root_r[SQ_STAGES-1];
      m1_e1_r   <= shell_norm[NORM_W-1:HALF_W] * sq_root_r[SQ_STAGES-1];
      m2_item_r <= m1_item_r;
      m2_prod_r <= {{(PROD_W-2*HALF_W){1'b0}}, m1_p00_r}
                 + {{(PROD_W-3*HALF_W){1'b0}}, m1_p01_r, {HALF_W{1'b0}}}
                 + {{(PROD_W-3*HALF_W){1'b0}}, m1_p10_r, {HALF_W{1'b0}}}
                 + {m1_p11_r, {(2*HALF_W){1'b0}}};
      m2_eprod_r <= {{(EPROD_W-HALF_W-ROOT_W){1'b0}}, m1_e0_r}
                  + {m1_e1_r, {HALF_W{1'b0}}};
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_item_r[k] <= dv_item_nxt[k];
        dv_covf_r[k] <= dv_covf_nxt[k];
        dv_crem_r[k] <= dv_crem_nxt[k];
        dv_clo_r[k]  <= dv_clo_nxt[k];
        dv_cq_r[k]   <= dv_cq_nxt[k];
        dv_eovf_r[k] <= dv_eovf_nxt[k];
        dv_erem_r[k] <= dv_erem_nxt[k];
        dv_elo_r[k]  <= dv_elo_nxt[k];
        dv_eq_r[k]   <= dv_eq_nxt[k];
      end
      out_bin_r     <= out_bin_nxt;
      out_corr_r    <= out_corr_nxt;
      out_err_r     <= out_err_nxt;
      out_clamped_r <= dv_item_r[DIV_STEPS].clamped;
    end
  end

endmodule

`default_nettype wire

>>> sv/pair_count_correlation.sv
`timescale 1ns / 1ps
`default_nettype none

// Natural-estimator correlation of one radial bin per item. The block takes a new
// item every cycle while the output is not stalled and returns one result per item,
// in order: the item passes through the bit-per-stage square root of the count, the
// split multipliers, divider setup, the bit-per-stage divide by the shell factor,
// and the output register.
// A short queue between the classifying front end and the arithmetic pipeline
// absorbs input while the output is held. Write object_count and shell_norm only
// while no item is in flight; the configuration channel is always ready.

module pair_count_correlation import pcc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Fields from bit 0 up: bin_index[5:0], pair_count[53:6], zero fill.
  input  logic [55:0]          in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0 up: bin_number[5:0], correlation[37:6], error_bar[68:38],
  // zero fill.
  output logic [71:0]          out_tdata,
  // Fields from bit 0 up: count_clamped.
  output logic                 out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NORM_W-1:0]    cfg_data
);

  logic [OBJ_W-1:0]  object_count_r;
  logic [NORM_W-1:0] shell_norm_r;
  bin_item_t         front_item;
  bin_item_t         q_head;
  logic              q_full, q_empty, q_pop;
  logic [BIN_W-1:0]  res_bin;
  logic [CORR_W-1:0] res_corr;
  logic [ERR_W-1:0]  res_err;
  logic              res_clamped;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_count_r <= OBJ_W'(1);
      shell_norm_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OBJECT_COUNT: object_count_r <= cfg_data[OBJ_W-1:0];
        REG_SHELL_NORM:   shell_norm_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  pcc_front u_front (
    .bin_index    (in_tdata[BIN_W-1:0]),
    .pair_count   (in_tdata[BIN_W +: CNT_W]),
    .object_count (object_count_r),
    .item         (front_item)
  );

  pcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .shell_norm  (shell_norm_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_bin     (res_bin),
    .out_corr    (res_corr),
    .out_err     (res_err),
    .out_clamped (res_clamped)
  );

  assign out_tdata = {3'b000, res_err, res_corr, res_bin};
  assign out_tuser = res_clamped;

  // A clamped count can only come from bin zero.
  a_clamp_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[5:0] == 6'd0)
    else $error("clamped flag on a bin other than zero");

  // A clamped count is a zero count, so both values are zero.
  a_clamp_zero_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[68:6] == 63'd0)
    else $error("clamped bin with nonzero correlation or error");

  // Correlation never drops below -1.0.
  a_corr_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[37:6]) >= -32'sd65536)
    else $error("correlation below -1.0");

endmodule

`default_nettype wire
